// ===== src/lpr_pkg.sv =====
// shared constants for the lru page replacement block
package lpr_pkg;

	// configuration port
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;
	localparam int CFG_W   = 5;

	// register index, taken from paddr bit 2
	localparam logic REG_FRAMES_IN_USE = 1'b0;

	localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

	// fault counter
	localparam int FAULT_W = 32;
	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

endpackage

// ===== src/lpr_ram.sv =====
// generic single-write, single-read ram with registered read data
module lpr_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/lru_page_replacement.sv =====
// lru page replacement: fully associative frame store with rank-ordered recency
//
// Request channel (req_valid/req_ready, page) carries one page reference.
// Result channel (res_valid/res_ready) returns hit, slot, evicted_valid,
// evicted_page and the saturating fault_count, one result per request.
// Frame pages and recency ranks live in one ram with a registered read;
// frame valid bits are flip-flops.
// A request takes a scan pass over the n active frames, a decide state,
// and for a hit or an eviction a second read-modify-write pass over the
// frames that ages the ranks. Filling an empty frame skips the second pass.
// The next request is taken as soon as the result sits in the output
// register; a stalled receiver holds the result there, and a following
// request finishes its passes and then waits for the register to free up.
// Reset empties all frames, zeroes the fault count and sets frames_in_use
// to 16. Writing frames_in_use (APB, address 0) empties all frames and
// zeroes the fault count at once; pready is always high.
module lru_page_replacement #(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [lpr_pkg::PADDR_W-1:0]             paddr,
	input  logic [lpr_pkg::DATA_W-1:0]              pwdata,
	output logic [lpr_pkg::DATA_W-1:0]              prdata,
	output logic                                    pready,
	input  logic                                    req_valid,
	output logic                                    req_ready,
	input  logic [PAGE_BITS-1:0]                    page,
	output logic                                    res_valid,
	input  logic                                    res_ready,
	output logic                                    hit,
	output logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] slot,
	output logic                                    evicted_valid,
	output logic [PAGE_BITS-1:0]                    evicted_page,
	output logic [lpr_pkg::FAULT_W-1:0]             fault_count
);

	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W  = $clog2(FRAMES + 1);
	localparam int RANK_W = IDX_W;
	localparam int WORD_W = PAGE_BITS + RANK_W;
	localparam int FIU_RST = int'(lpr_pkg::FRAMES_IN_USE_RST);
	localparam logic [CNT_W-1:0] NACT_RST = CNT_W'((FRAMES < FIU_RST) ? FRAMES : FIU_RST);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_FIXUP,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [lpr_pkg::CFG_W-1:0]     fiu_q;
	logic [CNT_W-1:0]              nact_q;
	logic [FRAMES-1:0]             vld_q;
	logic [lpr_pkg::FAULT_W-1:0]   faults_q;
	logic                          res_valid_q;
	logic [CNT_W-1:0]              rd_idx_q;
	logic                          rd_valid_s1;
	logic [IDX_W-1:0]              rd_idx_s1;

	// per-request working registers
	logic [PAGE_BITS-1:0]          page_q;
	logic [CNT_W-1:0]              used_q;
	logic                          hit_q;
	logic [IDX_W-1:0]              hit_slot_q;
	logic [RANK_W-1:0]             hit_rank_q;
	logic                          empty_found_q;
	logic [IDX_W-1:0]              empty_slot_q;
	logic                          zero_found_q;
	logic [IDX_W-1:0]              victim_slot_q;
	logic [PAGE_BITS-1:0]          victim_page_q;
	logic [IDX_W-1:0]              tgt_slot_q;
	logic [RANK_W-1:0]             tgt_rank_q;
	logic [RANK_W-1:0]             thr_q;
	logic                          evict_q;

	// result register
	logic                          hit_o_q;
	logic [IDX_W-1:0]              slot_o_q;
	logic                          evict_o_q;
	logic [PAGE_BITS-1:0]          evpage_o_q;
	logic [lpr_pkg::FAULT_W-1:0]   fault_o_q;

	logic                          cfg_wr;
	logic [CNT_W-1:0]              cfg_nact;
	logic                          rd_issue;
	logic                          rd_last;
	logic                          res_load;
	logic                          fill;
	logic [WORD_W-1:0]             ram_rdata;
	logic [PAGE_BITS-1:0]          r_page;
	logic [RANK_W-1:0]             r_rank;
	logic                          r_vld;
	logic [RANK_W-1:0]             new_rank;
	logic                          ram_we;
	logic [IDX_W-1:0]              ram_waddr;
	logic [WORD_W-1:0]             ram_wdata;

	assign pready    = 1'b1;
	assign req_ready = (state_q == ST_IDLE);
	assign cfg_wr    = psel && penable && pwrite && (paddr[2] == lpr_pkg::REG_FRAMES_IN_USE);
	assign prdata    = (paddr[2] == lpr_pkg::REG_FRAMES_IN_USE) ?
		lpr_pkg::DATA_W'(fiu_q) : '0;

	// active count: zero acts as one, too many acts as all frames
	always_comb begin
		if (pwdata[lpr_pkg::CFG_W-1:0] == '0) begin
			cfg_nact = CNT_W'(1);
		end else if (int'(pwdata[lpr_pkg::CFG_W-1:0]) > FRAMES) begin
			cfg_nact = CNT_W'(FRAMES);
		end else begin
			cfg_nact = CNT_W'(pwdata[lpr_pkg::CFG_W-1:0]);
		end
	end

	assign rd_issue = ((state_q == ST_SCAN) || (state_q == ST_FIXUP)) && (rd_idx_q < nact_q);
	assign rd_last  = rd_valid_s1 && (CNT_W'(rd_idx_s1) == nact_q - CNT_W'(1));
	assign res_load = (state_q == ST_DONE) && (!res_valid_q || res_ready);
	assign fill     = !hit_q && empty_found_q;

	assign r_page = ram_rdata[WORD_W-1:RANK_W];
	assign r_rank = ram_rdata[RANK_W-1:0];
	assign r_vld  = vld_q[rd_idx_s1];

	// aging: frames more recent than the threshold move down one rank; the target frame takes its new rank
	always_comb begin
		if (rd_idx_s1 == tgt_slot_q) begin
			new_rank = tgt_rank_q;
		end else if (r_rank > thr_q) begin
			new_rank = r_rank - RANK_W'(1);
		end else begin
			new_rank = r_rank;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_idx_s1;
		ram_wdata = {(rd_idx_s1 == tgt_slot_q) ? page_q : r_page, new_rank};
		if (state_q == ST_FIXUP) begin
			ram_we = rd_valid_s1 && r_vld;
		end else if (state_q == ST_DECIDE && fill) begin
			ram_we    = 1'b1;
			ram_waddr = empty_slot_q;
			ram_wdata = {page_q, RANK_W'(used_q)};
		end
	end

	lpr_ram #(
		.WIDTH(WORD_W),
		.DEPTH(FRAMES)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (rd_issue),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fiu_q       <= lpr_pkg::FRAMES_IN_USE_RST;
			nact_q      <= NACT_RST;
			vld_q       <= '0;
			faults_q    <= '0;
			res_valid_q <= 1'b0;
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			rd_idx_s1   <= '0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			rd_valid_s1 <= rd_issue;
			rd_idx_s1   <= rd_idx_q[IDX_W-1:0];
			if (rd_issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						rd_idx_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_last) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!hit_q && faults_q != lpr_pkg::FAULT_MAX) begin
						faults_q <= faults_q + lpr_pkg::FAULT_W'(1);
					end
					if (fill) begin
						vld_q[empty_slot_q] <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						rd_idx_q <= '0;
						state_q  <= ST_FIXUP;
					end
				end
				ST_FIXUP: begin
					if (rd_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// clearing the store
			if (cfg_wr) begin
				fiu_q    <= pwdata[lpr_pkg::CFG_W-1:0];
				nact_q   <= cfg_nact;
				vld_q    <= '0;
				faults_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			page_q        <= page;
			used_q        <= '0;
			hit_q         <= 1'b0;
			empty_found_q <= 1'b0;
			zero_found_q  <= 1'b0;
		end
		if (state_q == ST_SCAN && rd_valid_s1) begin
			if (r_vld) begin
				used_q <= used_q + CNT_W'(1);
				if (!hit_q && r_page == page_q) begin
					hit_q      <= 1'b1;
					hit_slot_q <= rd_idx_s1;
					hit_rank_q <= r_rank;
				end
				if (!zero_found_q && r_rank == '0) begin
					zero_found_q  <= 1'b1;
					victim_slot_q <= rd_idx_s1;
					victim_page_q <= r_page;
				end
			end else if (!empty_found_q) begin
				empty_found_q <= 1'b1;
				empty_slot_q  <= rd_idx_s1;
			end
		end
		if (state_q == ST_DECIDE) begin
			if (hit_q) begin
				tgt_slot_q <= hit_slot_q;
				tgt_rank_q <= RANK_W'(used_q - CNT_W'(1));
				thr_q      <= hit_rank_q;
				evict_q    <= 1'b0;
			end else if (empty_found_q) begin
				tgt_slot_q <= empty_slot_q;
				tgt_rank_q <= RANK_W'(used_q);
				thr_q      <= '0;
				evict_q    <= 1'b0;
			end else begin
				tgt_slot_q <= victim_slot_q;
				tgt_rank_q <= RANK_W'(used_q - CNT_W'(1));
				thr_q      <= '0;
				evict_q    <= 1'b1;
			end
		end
		if (res_load) begin
			hit_o_q    <= hit_q;
			slot_o_q   <= tgt_slot_q;
			evict_o_q  <= evict_q;
			evpage_o_q <= evict_q ? victim_page_q : '0;
			fault_o_q  <= faults_q;
		end
	end

	assign res_valid     = res_valid_q;
	assign hit           = hit_o_q;
	assign slot          = slot_o_q;
	assign evicted_valid = evict_o_q;
	assign evicted_page  = evpage_o_q;
	assign fault_count   = fault_o_q;

endmodule

// ===== src/lpr_checker.sv =====
// port-level checks for the lru page replacement block
module lpr_checker #(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 16
) (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    psel,
	input logic                                    penable,
	input logic                                    pwrite,
	input logic [lpr_pkg::PADDR_W-1:0]             paddr,
	input logic [lpr_pkg::DATA_W-1:0]              pwdata,
	input logic [lpr_pkg::DATA_W-1:0]              prdata,
	input logic                                    pready,
	input logic                                    req_valid,
	input logic                                    req_ready,
	input logic [PAGE_BITS-1:0]                    page,
	input logic                                    res_valid,
	input logic                                    res_ready,
	input logic                                    hit,
	input logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] slot,
	input logic                                    evicted_valid,
	input logic [PAGE_BITS-1:0]                    evicted_page,
	input logic [lpr_pkg::FAULT_W-1:0]             fault_count
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(slot) && $stable(fault_count))
		else $error("result changed while stalled");

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(hit && evicted_valid))
		else $error("hit reported with eviction");

	a_evpage_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !evicted_valid |-> evicted_page == '0)
		else $error("evicted page not zero without eviction");

	// one request in flight at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[2] == lpr_pkg::REG_FRAMES_IN_USE)
		|=> (paddr[2] != lpr_pkg::REG_FRAMES_IN_USE) ||
		(prdata == lpr_pkg::DATA_W'($past(pwdata[lpr_pkg::CFG_W-1:0]))))
		else $error("frames_in_use readback mismatch");

endmodule

bind lru_page_replacement lpr_checker #(
	.FRAMES(FRAMES),
	.PAGE_BITS(PAGE_BITS)
) u_lpr_checker (.*);

// ===== tb/sv/lru_page_replacement_tb.sv =====
// testbench for lru_page_replacement: lru predictor, paging traffic and apb frame-count phases
`timescale 1ns / 1ps

module lru_page_replacement_tb;

	localparam int FRAMES          = 16;
	localparam int PAGE_BITS       = 16;
	localparam int SLOT_W          = 4;
	localparam logic REG_UNMAPPED  = 1'b1;
	localparam int IDLE_PCT        = 27;
	localparam int STALL_LIMIT     = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 40;
	localparam int MAX_SET         = FRAMES + 4;

	typedef struct packed {
		logic                        hit;
		logic [SLOT_W-1:0]           slot;
		logic                        evicted_valid;
		logic [PAGE_BITS-1:0]        evicted_page;
		logic [lpr_pkg::FAULT_W-1:0] fault_count;
	} access_result_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          psel      = 1'b0;
	logic                          penable   = 1'b0;
	logic                          pwrite    = 1'b0;
	logic [lpr_pkg::PADDR_W-1:0]   paddr     = '0;
	logic [lpr_pkg::DATA_W-1:0]    pwdata    = '0;
	logic [lpr_pkg::DATA_W-1:0]    prdata;
	logic                          pready;
	logic                          req_valid = 1'b0;
	logic                          req_ready;
	logic [PAGE_BITS-1:0]          page      = '0;
	logic                          res_valid;
	logic                          res_ready = 1'b0;
	logic                          hit;
	logic [SLOT_W-1:0]             slot;
	logic                          evicted_valid;
	logic [PAGE_BITS-1:0]          evicted_page;
	logic [lpr_pkg::FAULT_W-1:0]   fault_count;

	// predicted store contents
	logic [lpr_pkg::CFG_W-1:0]     frames_cfg;
	logic [PAGE_BITS-1:0]          resident_page [FRAMES];
	logic                          resident      [FRAMES];
	int                            lru_rank      [FRAMES];
	logic [lpr_pkg::FAULT_W-1:0]   faults_seen;

	access_result_t pending_results[$];
	int fail_count      = 0;
	int req_idle_pct    = IDLE_PCT;
	int res_idle_pct    = IDLE_PCT;
	int hold_off_cycles = 0;
	int quiet_cycles    = 0;

	lru_page_replacement #(
		.FRAMES(FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.page(page),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.hit(hit),
		.slot(slot),
		.evicted_valid(evicted_valid),
		.evicted_page(evicted_page),
		.fault_count(fault_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int active_frames(logic [lpr_pkg::CFG_W-1:0] cfg);
		if (cfg == 0)
			return 1;
		if (cfg > FRAMES)
			return FRAMES;
		return int'(cfg);
	endfunction

	function automatic void clear_frames();
		for (int i = 0; i < FRAMES; i++) begin
			resident[i] = 1'b0;
			lru_rank[i] = 0;
		end
		faults_seen = '0;
	endfunction

	// one page reference against the predicted store; rank 0 is least recently used
	function automatic access_result_t lru_access(logic [PAGE_BITS-1:0] pg);
		access_result_t res;
		int n;
		int used;
		int r;
		bit found;
		res   = '0;
		found = 1'b0;
		used  = 0;
		n     = active_frames(frames_cfg);
		for (int i = 0; i < n; i++)
			if (resident[i])
				used++;
		for (int i = 0; i < n && !found; i++)
			if (resident[i] && resident_page[i] == pg) begin
				res.slot = SLOT_W'(i);
				found    = 1'b1;
			end
		if (found) begin
			res.hit = 1'b1;
			r = lru_rank[res.slot];
			for (int i = 0; i < n; i++)
				if (resident[i] && lru_rank[i] > r)
					lru_rank[i]--;
			lru_rank[res.slot] = used - 1;
		end else begin
			for (int i = 0; i < n && !found; i++)
				if (!resident[i]) begin
					res.slot = SLOT_W'(i);
					found    = 1'b1;
				end
			if (found) begin
				resident[res.slot]      = 1'b1;
				resident_page[res.slot] = pg;
				lru_rank[res.slot]      = used;
			end else begin
				// every active frame full: replace the one ranked least recent
				for (int i = 0; i < n && !found; i++)
					if (lru_rank[i] == 0) begin
						res.slot = SLOT_W'(i);
						found    = 1'b1;
					end
				res.evicted_valid = 1'b1;
				res.evicted_page  = resident_page[res.slot];
				for (int i = 0; i < n; i++)
					if (lru_rank[i] > 0)
						lru_rank[i]--;
				resident_page[res.slot] = pg;
				lru_rank[res.slot]      = used - 1;
			end
			if (faults_seen != lpr_pkg::FAULT_MAX)
				faults_seen++;
		end
		res.fault_count = faults_seen;
		return res;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : result_checker
		access_result_t want;
		if (res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: hit %0d slot %0d evicted %0d page 0x%0h faults %0d",
					$time, hit, slot, evicted_valid, evicted_page, fault_count);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("hit", want.hit, hit);
				compare_field("slot", want.slot, slot);
				compare_field("evicted_valid", want.evicted_valid, evicted_valid);
				compare_field("evicted_page", want.evicted_page, evicted_page);
				compare_field("fault_count", want.fault_count, fault_count);
			end
		end
	end

	// result side: random stalls, or a long hold-off when a test asks for one
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			res_ready <= 1'b0;
			hold_off_cycles--;
		end else begin
			res_ready <= ($urandom_range(99) >= res_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (res_valid && res_ready) || (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("lru_page_replacement_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic send_page(input logic [PAGE_BITS-1:0] pg);
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		page      <= pg;
		do @(posedge clk); while (!req_ready);
		pending_results.push_back(lru_access(pg));
	endtask

	task automatic wait_until_idle();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// apb write, then read frames_in_use back
	task automatic write_register(input logic idx, input logic [lpr_pkg::DATA_W-1:0] data);
		wait_until_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == lpr_pkg::REG_FRAMES_IN_USE) begin
			frames_cfg = data[lpr_pkg::CFG_W-1:0];
			clear_frames();
		end
		pwrite  <= 1'b0;
		penable <= 1'b0;
		paddr   <= {lpr_pkg::REG_FRAMES_IN_USE, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		compare_field("prdata", lpr_pkg::DATA_W'(frames_cfg), prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_frames_in_use(input logic [lpr_pkg::CFG_W-1:0] cfg);
		logic [lpr_pkg::DATA_W-1:0] data;
		// junk in the upper bits must be dropped
		data = $urandom();
		data[lpr_pkg::CFG_W-1:0] = cfg;
		write_register(lpr_pkg::REG_FRAMES_IN_USE, data);
	endtask

	// working set usually a little larger than the frame count, else no larger, with repeats and stray pages
	task automatic run_paging_phase(input logic [lpr_pkg::CFG_W-1:0] cfg, input int count);
		logic [PAGE_BITS-1:0] working_set [MAX_SET];
		logic [PAGE_BITS-1:0] pg;
		logic [PAGE_BITS-1:0] last_pg;
		int n;
		int set_size;
		int roll;
		set_frames_in_use(cfg);
		n = active_frames(cfg);
		if (n > 1 && $urandom_range(3) == 0)
			set_size = $urandom_range(1, n);
		else
			set_size = n + $urandom_range(1, 4);
		for (int i = 0; i < set_size; i++)
			working_set[i] = PAGE_BITS'($urandom());
		last_pg = working_set[0];
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			if (roll < 80)
				pg = working_set[$urandom_range(set_size - 1)];
			else if (roll < 90)
				pg = last_pg;
			else
				pg = PAGE_BITS'($urandom());
			send_page(pg);
			last_pg = pg;
		end
	endtask

	task automatic test_fill_hit_evict();
		logic [PAGE_BITS-1:0] fill_pages [FRAMES];
		fill_pages = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000,
			16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h1234, 16'h4321,
			16'h3C3C, 16'hC3C3, 16'h7FFF, 16'hFFFE};
		foreach (fill_pages[i])
			send_page(fill_pages[i]);
		send_page(16'h0000); // least recent frame becomes most recent
		send_page(16'hFFFF);
		send_page(16'h4242); // replaces 5555
		send_page(16'h0000);
		send_page(16'h5555); // faults again
		send_page(16'hFFFE);
	endtask

	task automatic test_frame_count_limits();
		set_frames_in_use('0); // zero acts as one frame
		send_page(16'h0011);
		send_page(16'h0011);
		send_page(16'h0022);
		send_page(16'h0011);
		set_frames_in_use(5'd31); // above the store size: all frames
		send_page(16'h0011);
		send_page(16'h0022);
		send_page(16'h0011);
		set_frames_in_use(5'd1);
		send_page(16'h0033);
		send_page(16'h0044);
		send_page(16'h0044);
		set_frames_in_use(5'd2);
		send_page(16'h0055);
		send_page(16'h0066);
		send_page(16'h0055);
		send_page(16'h0077); // replaces 0066
		send_page(16'h0066);
		// write to an unmapped index leaves the store alone
		write_register(REG_UNMAPPED, $urandom());
		send_page(16'h0066);
		send_page(16'h0077);
		set_frames_in_use(5'd16);
		send_page(16'h0066);
	endtask

	task automatic test_back_to_back();
		wait_until_idle();
		@(negedge clk);
		req_idle_pct = 0;
		res_idle_pct = 0;
		@(posedge clk);
		run_paging_phase(5'd16, 120);
		wait_until_idle();
		@(negedge clk);
		req_idle_pct = IDLE_PCT;
		res_idle_pct = IDLE_PCT;
		@(posedge clk);
	endtask

	// receiver stalls long enough that the block backs up into the request side
	task automatic test_result_hold_off();
		wait_until_idle();
		@(negedge clk);
		hold_off_cycles = HOLD_OFF_CYCLES;
		@(posedge clk);
		run_paging_phase(5'd4, 30);
	endtask

	task automatic test_random_paging();
		logic [lpr_pkg::CFG_W-1:0] cfg;
		int roll;
		for (int p = 0; p < 15; p++) begin
			roll = $urandom_range(99);
			if (roll < 8)
				cfg = '0;
			else if (roll < 16)
				cfg = lpr_pkg::CFG_W'($urandom_range(FRAMES + 1, 31));
			else if (roll < 30)
				cfg = lpr_pkg::CFG_W'(FRAMES);
			else
				cfg = lpr_pkg::CFG_W'($urandom_range(1, FRAMES));
			run_paging_phase(cfg, 50);
		end
	endtask

	initial begin
		frames_cfg = lpr_pkg::FRAMES_IN_USE_RST;
		clear_frames();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_hit_evict();
		test_frame_count_limits();
		test_back_to_back();
		test_result_hold_off();
		test_random_paging();
		wait_until_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("lru_page_replacement_tb: PASS");
		else
			$display("lru_page_replacement_tb: FAIL");
		$finish;
	end

endmodule
